### hw/rtl/bsc_pkg.sv
// Shared types and constants for the barometric sensor compensation pipeline.
// No dependencies; every other file in hw/rtl imports this package.
package bsc_pkg;

  localparam int unsigned RawW     = 20;
  localparam int unsigned TcW      = 24;
  localparam int unsigned FineW    = 32;
  localparam int unsigned PressW   = 32;
  localparam int unsigned DivW     = 64;
  localparam int unsigned TrimW    = 48;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 5;

  // Arithmetic constants of the compensation scheme
  localparam int OffsetT = 128000;
  localparam int PBase   = 1048576;
  localparam int PScale  = 3125;
  localparam int Round   = 128;
  localparam int Scale5  = 5;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_TEMP_TRIM    = 2'd0,
    REG_PRESS_TRIM_A = 2'd1,
    REG_PRESS_TRIM_B = 2'd2,
    REG_PRESS_TRIM_C = 2'd3
  } reg_idx_t;

  // Decoded calibration words
  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } trim_t;

  // Temperature section result
  typedef struct packed {
    logic signed [FineW-1:0] fine;
    logic        [RawW-1:0]  raw_p;
  } temp_res_t;

  // Fields that ride alongside the pressure datapath
  typedef struct packed {
    logic signed [TcW-1:0]   tc;
    logic signed [FineW-1:0] fine;
    logic                    invalid;
  } side_t;

  // Dividend and divisor handed to the divider
  typedef struct packed {
    logic signed [DivW-1:0] num;
    logic signed [DivW-1:0] den;
    side_t                  side;
  } frac_t;

  // Divider result as magnitude and sign
  typedef struct packed {
    logic [DivW-1:0] qmag;
    logic            qneg;
    side_t           side;
  } quot_t;

  // Final result item
  typedef struct packed {
    logic signed [TcW-1:0]   tc;
    logic signed [FineW-1:0] fine;
    logic        [PressW-1:0] press;
    logic                    invalid;
  } result_t;

endpackage

### hw/rtl/barometric_sensor_compensation.sv
// Pipeline from item acceptance to result: 3 temperature stages, 6 coefficient stages,
// 65 divider stages and 6 post-division stages.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous, active low) clears all valid bits and the four trim registers.
// Top level: APB trim registers, trim decoding and the compensation pipeline.
// Depends on bsc_pkg, bsc_temp, bsc_pcoef, bsc_div and bsc_post.
module barometric_sensor_compensation import bsc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // Input item: [19:0] raw_temperature, [39:20] raw_pressure
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [39:0]         in_tdata,
  // Result item: [23:0] temperature_centi, [55:24] fine_temperature,
  // [87:56] pressure_q24_8
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [87:0]         out_tdata,
  // Result flag: [0] pressure_invalid
  output logic                out_tuser,
  // Configuration port
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready
);

  logic [TrimW-1:0] temp_trim_r, press_trim_a_r, press_trim_b_r, press_trim_c_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;
  trim_t            trim;
  logic             pipe_en;

  logic      temp_v, pcoef_v, div_v, post_v;
  temp_res_t tres;
  frac_t     frac;
  quot_t     quot;
  result_t   res;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_trim_r    <= '0;
      press_trim_a_r <= '0;
      press_trim_b_r <= '0;
      press_trim_c_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TEMP_TRIM:    temp_trim_r    <= cfg_pwdata[TrimW-1:0];
        REG_PRESS_TRIM_A: press_trim_a_r <= cfg_pwdata[TrimW-1:0];
        REG_PRESS_TRIM_B: press_trim_b_r <= cfg_pwdata[TrimW-1:0];
        REG_PRESS_TRIM_C: press_trim_c_r <= cfg_pwdata[TrimW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (cfg_idx)
      REG_TEMP_TRIM:    cfg_prdata = CfgDataW'(temp_trim_r);
      REG_PRESS_TRIM_A: cfg_prdata = CfgDataW'(press_trim_a_r);
      REG_PRESS_TRIM_B: cfg_prdata = CfgDataW'(press_trim_b_r);
      REG_PRESS_TRIM_C: cfg_prdata = CfgDataW'(press_trim_c_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // Split the trim registers into calibration words
  assign trim.t1 = temp_trim_r[15:0];
  assign trim.t2 = temp_trim_r[31:16];
  assign trim.t3 = temp_trim_r[47:32];
  assign trim.p1 = press_trim_a_r[15:0];
  assign trim.p2 = press_trim_a_r[31:16];
  assign trim.p3 = press_trim_a_r[47:32];
  assign trim.p4 = press_trim_b_r[15:0];
  assign trim.p5 = press_trim_b_r[31:16];
  assign trim.p6 = press_trim_b_r[47:32];
  assign trim.p7 = press_trim_c_r[15:0];
  assign trim.p8 = press_trim_c_r[31:16];
  assign trim.p9 = press_trim_c_r[47:32];

  // The pipeline advances unless a finished result is waiting
  assign pipe_en   = !out_tvalid || out_tready;
  assign in_tready = pipe_en;

  bsc_temp u_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (in_tvalid),
    .raw_t     (in_tdata[19:0]),
    .raw_p     (in_tdata[39:20]),
    .trim      (trim),
    .out_valid (temp_v),
    .res       (tres)
  );

  bsc_pcoef u_pcoef (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (temp_v),
    .tres      (tres),
    .trim      (trim),
    .out_valid (pcoef_v),
    .frac      (frac)
  );

  bsc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (pcoef_v),
    .frac      (frac),
    .out_valid (div_v),
    .quot      (quot)
  );

  bsc_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (div_v),
    .quot      (quot),
    .trim      (trim),
    .out_valid (post_v),
    .res       (res)
  );

  assign out_tvalid = post_v;
  assign out_tdata  = {res.press, res.fine, res.tc};
  assign out_tuser  = res.invalid;

  // A zero divisor always reports zero pressure
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[87:56] == 32'd0)
    else $error("pressure not zero on an invalid result");

  // A waiting result holds off new items
  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

### hw/rtl/bsc_temp.sv
// Temperature section: three stages producing the fine temperature (int32 wrap).
// Depends on bsc_pkg.
module bsc_temp import bsc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [RawW-1:0] raw_t,
  input  logic [RawW-1:0] raw_p,
  input  trim_t           trim,
  output logic            out_valid,
  output temp_res_t       res
);

  logic signed [17:0] d1, d2;
  logic signed [33:0] m1_full;
  logic signed [35:0] m2_full;
  logic signed [35:0] m3_full;

  logic               v1_r, v2_r, v3_r;
  logic signed [31:0] m1_r, m2_r, m3_r;
  logic signed [20:0] v1_r_val;
  logic [RawW-1:0]    rp1_r, rp2_r, rp3_r;
  logic signed [31:0] fine_r;

  // Stage one: differences against T1 and the two products
  assign d1      = 18'(raw_t >> 3) - 18'({trim.t1, 1'b0});
  assign d2      = 18'(raw_t >> 4) - 18'(trim.t1);
  assign m1_full = d1 * trim.t2;
  assign m2_full = d2 * d2;

  // Stage two: scaled square times T3
  assign m3_full = $signed(m2_r[31:12]) * trim.t3;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      m1_r     <= m1_full[31:0];
      m2_r     <= m2_full[31:0];
      rp1_r    <= raw_p;
      v1_r_val <= m1_r[31:11];
      m3_r     <= m3_full[31:0];
      rp2_r    <= rp1_r;
      fine_r   <= 32'(v1_r_val) + 32'($signed(m3_r[31:14]));
      rp3_r    <= rp2_r;
    end
  end

  assign out_valid = v3_r;
  assign res.fine  = fine_r;
  assign res.raw_p = rp3_r;

endmodule

### hw/rtl/bsc_pcoef.sv
// Pressure coefficient section: six stages forming the dividend and divisor.
// Depends on bsc_pkg; 64-bit intermediates wrap.
module bsc_pcoef import bsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  temp_res_t tres,
  input  trim_t     trim,
  output logic      out_valid,
  output frac_t     frac
);

  localparam logic signed [63:0] ABias = 64'sd1 <<< 47;

  logic [5:0] v_r;

  logic [31:0] tcw;
  logic signed [32:0] a_nxt;
  logic signed [65:0] aa_full;

  // Stage registers
  logic signed [32:0] a_r;
  logic signed [63:0] aa_r, b1_r, a1_r, bpart_r, apart_r, b_r, x_r, m_r, n0_r;
  logic signed [48:0] ap5_r, ap2_r;
  logic [RawW-1:0]    rp1_r, rp2_r, rp3_r, rp4_r;
  side_t              s1_r, s2_r, s3_r, s4_r, s5_r;
  frac_t              frac_r;

  // Stage one: compensated temperature and centred fine temperature
  assign tcw   = 32'(tres.fine * Scale5) + 32'(Round);
  assign a_nxt = 33'(tres.fine) - 33'(OffsetT);
  assign aa_full = a_r * a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage one
      a_r        <= a_nxt;
      s1_r.tc    <= tcw[31:8];
      s1_r.fine  <= tres.fine;
      s1_r.invalid <= 1'b0;
      rp1_r      <= tres.raw_p;
      // Stage two: square and linear terms
      aa_r  <= aa_full[63:0];
      ap5_r <= a_r * trim.p5;
      ap2_r <= a_r * trim.p2;
      s2_r  <= s1_r;
      rp2_r <= rp1_r;
      // Stage three: quadratic terms and shifted linear terms
      b1_r    <= aa_r * trim.p6;
      a1_r    <= aa_r * trim.p3;
      bpart_r <= (64'(ap5_r) <<< 17) + (64'(trim.p4) <<< 35);
      apart_r <= 64'(ap2_r) <<< 12;
      s3_r    <= s2_r;
      rp3_r   <= rp2_r;
      // Stage four: sums
      b_r   <= b1_r + bpart_r;
      x_r   <= (a1_r >>> 8) + apart_r + ABias;
      s4_r  <= s3_r;
      rp4_r <= rp3_r;
      // Stage five: P1 scaling and raw pressure term
      m_r   <= x_r * $signed({1'b0, trim.p1});
      n0_r  <= (64'(21'(PBase) - 21'(rp4_r)) << 31) - b_r;
      s5_r  <= s4_r;
      // Stage six: divisor, scaled dividend, zero-divisor flag
      frac_r.den          <= m_r >>> 33;
      frac_r.num          <= n0_r * 64'(PScale);
      frac_r.side.tc      <= s5_r.tc;
      frac_r.side.fine    <= s5_r.fine;
      frac_r.side.invalid <= ((m_r >>> 33) == 64'sd0);
    end
  end

  assign out_valid = v_r[5];
  assign frac      = frac_r;

endmodule

### hw/rtl/bsc_div.sv
// Pipelined signed 64-bit divider: sign stage then one restoring step per stage.
// Depends on bsc_pkg; truncates toward zero, magnitude and sign kept apart.
module bsc_div import bsc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  frac_t frac,
  output logic  out_valid,
  output quot_t quot
);

  logic [DivW-1:0] rem_r  [DivW+1];
  logic [DivW-1:0] nq_r   [DivW+1];
  logic [DivW-1:0] dv_r   [DivW+1];
  logic            qneg_r [DivW+1];
  side_t           side_r [DivW+1];
  logic            v_r    [DivW+1];

  logic nneg, dneg;

  assign nneg = frac.num[DivW-1];
  assign dneg = frac.den[DivW-1];

  // Sign stage: take magnitudes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      nq_r[0]   <= nneg ? DivW'(0) - DivW'(frac.num) : DivW'(frac.num);
      dv_r[0]   <= dneg ? DivW'(0) - DivW'(frac.den) : DivW'(frac.den);
      qneg_r[0] <= nneg ^ dneg;
      side_r[0] <= frac.side;
    end
  end

  // One quotient bit per stage; dividend bits shift out as quotient bits shift in
  for (genvar k = 0; k < DivW; k++) begin : g_step
    logic [DivW:0] trial;
    logic          ge;

    assign trial = {rem_r[k], nq_r[k][DivW-1]};
    assign ge    = trial >= {1'b0, dv_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? DivW'(trial - {1'b0, dv_r[k]}) : trial[DivW-1:0];
        nq_r[k+1]   <= {nq_r[k][DivW-2:0], ge};
        dv_r[k+1]   <= dv_r[k];
        qneg_r[k+1] <= qneg_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = v_r[DivW];
  assign quot.qmag = nq_r[DivW];
  assign quot.qneg = qneg_r[DivW];
  assign quot.side = side_r[DivW];

endmodule

### hw/rtl/bsc_post.sv
// Post-division section: sign, P7..P9 correction terms and final Q24.8 pressure.
// Depends on bsc_pkg; the last stage is the output register.
module bsc_post import bsc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    in_valid,
  input  quot_t   quot,
  input  trim_t   trim,
  output logic    out_valid,
  output result_t res
);

  logic [5:0] v_r;

  logic signed [63:0] q1_r, q2_r, q3_r, ph_r, p9ph_r, p8p_r, c2_r;
  logic        [63:0] pl_r;
  logic        [31:0] x1_r, x2_r;
  logic signed [63:0] c1v_r, qc2_r, sum_r;
  side_t              s1_r, s2_r, s3_r, s4_r, s5_r;
  result_t            res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage one: apply the quotient sign
      q1_r <= quot.qneg ? DivW'(0) - quot.qmag : quot.qmag;
      s1_r <= quot.side;
      // Stage two: P9 and P8 products
      ph_r   <= q1_r >>> 13;
      p9ph_r <= (q1_r >>> 13) * trim.p9;
      p8p_r  <= q1_r * trim.p8;
      q2_r   <= q1_r;
      s2_r   <= s1_r;
      // Stage three: 64-bit wrapping product split into 32-bit partial products
      pl_r <= p9ph_r[31:0] * ph_r[31:0];
      x1_r <= p9ph_r[31:0] * ph_r[63:32];
      x2_r <= p9ph_r[63:32] * ph_r[31:0];
      c2_r <= p8p_r >>> 19;
      q3_r <= q2_r;
      s3_r <= s2_r;
      // Stage four: recombine and add the P8 term
      c1v_r <= pl_r + {x1_r + x2_r, 32'b0};
      qc2_r <= q3_r + c2_r;
      s4_r  <= s3_r;
      // Stage five: add the P9 term
      sum_r <= qc2_r + (c1v_r >>> 25);
      s5_r  <= s4_r;
      // Stage six: scale to Q24.8, add P7 offset, force zero on a zero divisor
      res_r.tc      <= s5_r.tc;
      res_r.fine    <= s5_r.fine;
      res_r.invalid <= s5_r.invalid;
      res_r.press   <= s5_r.invalid ? '0 : sum_r[39:8] + (32'(trim.p7) << 4);
    end
  end

  assign out_valid = v_r[5];
  assign res       = res_r;

endmodule
